// File: rtl/core/cwht_pkg.sv
// ---------------------------------------------------------------------------
// cwht_pkg - shared types and constants for the capsule wall hit test core
// Table entry layout, sequencer states, MAC micro-operations and the
// control word handed to the multiply-accumulate unit.
// ---------------------------------------------------------------------------
package cwht_pkg;

    localparam int MAX_WALLS = 64;
    localparam int ADDR_W    = $clog2(MAX_WALLS);
    localparam int CNT_W     = 7;
    localparam int CW        = 19;     // coordinate width
    localparam int DW        = CW + 1; // difference width
    localparam int RAD_W     = 10;
    localparam int THK_W     = 10;
    localparam int H_W       = 12;
    localparam int H2_W      = 24;
    localparam int L_W       = 40;
    localparam int CR_W      = 40;
    localparam int LO_W      = 21;
    localparam int A_W       = 24;
    localparam int B_W       = 21;
    localparam int P_W       = A_W + B_W;
    localparam int ACC_W     = 84;
    localparam int SH_W      = 6;

    localparam logic [SH_W-1:0] SH_NONE = 6'd0;
    localparam logic [SH_W-1:0] SH_LO   = 6'd21;
    localparam logic [SH_W-1:0] SH_MID  = 6'd22;
    localparam logic [SH_W-1:0] SH_HI   = 6'd42;

    localparam logic REG_EGG_RADIUS = 1'b0;
    localparam logic REG_WALL_COUNT = 1'b1;
    localparam logic OPC_LOAD       = 1'b0;
    localparam logic OPC_QUERY      = 1'b1;

    typedef struct packed {
        logic signed [CW-1:0] e1x;
        logic signed [CW-1:0] e1y;
        logic signed [CW-1:0] e2x;
        logic signed [CW-1:0] e2y;
        logic [THK_W-1:0]     thick;
    } wall_entry_t;

    typedef enum logic [2:0] {
        S_IDLE, S_RD, S_DIFF, S_MUL, S_ACC, S_SEL, S_CRM, S_CMP
    } state_t;

    typedef enum logic [3:0] {
        OP_H2, OP_L0, OP_L1, OP_T0, OP_T1, OP_W0, OP_W1, OP_E0,
        OP_E1, OP_C0, OP_C1, OP_Q0, OP_Q1, OP_Q2, OP_R0, OP_R1
    } op_t;

    typedef struct packed {
        logic            mul_en;
        logic            acc_en;
        logic            clear;
        logic            neg;
        logic [SH_W-1:0] shift;
    } mac_ctrl_t;

    // sign and magnitude of a - b
    function automatic logic [DW:0] diff_mag(input logic signed [CW-1:0] a,
                                             input logic signed [CW-1:0] b);
        logic signed [DW-1:0] d;
        logic [DW-1:0]        m;
        d = DW'(a) - DW'(b);
        m = d[DW-1] ? DW'(-d) : DW'(d);
        return {d[DW-1], m};
    endfunction

endpackage

// File: rtl/core/cwht_mac.sv
// ---------------------------------------------------------------------------
// cwht_mac - shared multiply-accumulate unit
// Registered unsigned multiply, then a signed shifted accumulate.
// ---------------------------------------------------------------------------
module cwht_mac (
    input  logic                               clk,
    input  cwht_pkg::mac_ctrl_t                ctrl,
    input  logic [cwht_pkg::A_W-1:0]           a,
    input  logic [cwht_pkg::B_W-1:0]           b,
    output logic signed [cwht_pkg::ACC_W-1:0]  acc
);
    import cwht_pkg::*;

    logic [P_W-1:0]          prod_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] addend;
    logic signed [ACC_W-1:0] base;

    assign addend = signed'(ACC_W'(prod_reg) << ctrl.shift);
    assign base   = ctrl.clear ? '0 : acc_reg;
    assign acc    = acc_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= P_W'(a) * P_W'(b);
        end
        if (ctrl.acc_en)
        begin
            acc_reg <= ctrl.neg ? base - addend : base + addend;
        end
    end

endmodule

// File: rtl/core/capsule_wall_hit_test_core.sv
// ---------------------------------------------------------------------------
// capsule_wall_hit_test_core - thick wall segment hit test
// Keeps a table of capsule walls and tests a point against the first
// wall_count of them (capped at 64) with exact fixed point arithmetic.
//
//  channel   handshake             payload
//  input     start / busy          opcode, wall_index, end*, thickness, point
//  result    done (one cycle)      was_query, hit
//  config    cfg_wr                cfg_index, cfg_data
//
// A load word is acknowledged on the cycle after acceptance; busy stays low.
// A query walks the walls through one shared 24x21 multiply-accumulate
// unit; a wall hit or missed near an end takes fewer products than the
// middle span, and a hit ends the walk early.
// Reset leaves radius 256 and count 0; table contents stay undefined.
// The receiver cannot stall: done lasts exactly one cycle.
// ---------------------------------------------------------------------------
module capsule_wall_hit_test_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              cfg_wr,
    input  logic                              cfg_index,
    input  logic [cwht_pkg::RAD_W-1:0]        cfg_data,
    input  logic                              opcode,
    input  logic [cwht_pkg::ADDR_W-1:0]       wall_index,
    input  logic signed [cwht_pkg::CW-1:0]    end1_x,
    input  logic signed [cwht_pkg::CW-1:0]    end1_y,
    input  logic signed [cwht_pkg::CW-1:0]    end2_x,
    input  logic signed [cwht_pkg::CW-1:0]    end2_y,
    input  logic [cwht_pkg::THK_W-1:0]        wall_thickness,
    input  logic signed [cwht_pkg::CW-1:0]    point_x,
    input  logic signed [cwht_pkg::CW-1:0]    point_y,
    output logic                              done,
    output logic                              was_query,
    output logic                              hit
);
    import cwht_pkg::*;

    wall_entry_t             wall_mem [MAX_WALLS];
    wall_entry_t             rd_q_reg;

    state_t                  state_reg, state_next;
    op_t                     op_reg, op_next;
    logic [ADDR_W-1:0]       idx_reg, idx_next;
    logic                    done_reg, done_next;
    logic                    wq_reg, wq_next;
    logic                    hit_reg, hit_next;
    logic                    cross_reg, cross_next;
    logic [RAD_W-1:0]        radius_reg;
    logic [CNT_W-1:0]        count_reg;

    logic signed [CW-1:0]    px_reg, py_reg;
    logic [DW-1:0]           mdx_reg, mdy_reg, mwx_reg, mwy_reg, mex_reg, mey_reg;
    logic                    sdx_reg, sdy_reg, swx_reg, swy_reg;
    logic [H_W-1:0]          h_reg;
    logic [H2_W-1:0]         h2_reg;
    logic [L_W-1:0]          l_reg;
    logic [CR_W-1:0]         cr_reg;
    logic [ACC_W-1:0]        lhs_reg;

    logic [DW:0]             dmx, dmy, dwx, dwy, dex, dey;
    logic                    accept;
    logic [CNT_W-1:0]        n_walls;
    logic                    last_wall;
    logic                    wall_hit;
    logic [ACC_W-1:0]        acc_u;

    mac_ctrl_t               ctrl;
    logic [A_W-1:0]          mac_a;
    logic [B_W-1:0]          mac_b;
    logic signed [ACC_W-1:0] acc;

    cwht_mac u_mac (
        .clk  (clk),
        .ctrl (ctrl),
        .a    (mac_a),
        .b    (mac_b),
        .acc  (acc)
    );

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign was_query = wq_reg;
    assign hit       = hit_reg;
    assign acc_u     = $unsigned(acc);

    assign n_walls   = (count_reg > CNT_W'(MAX_WALLS)) ? CNT_W'(MAX_WALLS) : count_reg;
    assign last_wall = (CNT_W'(idx_reg) == n_walls - CNT_W'(1));
    assign wall_hit  = cross_reg ? (lhs_reg <= acc_u)
                                 : ((acc_u << 2) <= ACC_W'(h2_reg));

    assign dmx = diff_mag(rd_q_reg.e2x, rd_q_reg.e1x);
    assign dmy = diff_mag(rd_q_reg.e2y, rd_q_reg.e1y);
    assign dwx = diff_mag(px_reg, rd_q_reg.e1x);
    assign dwy = diff_mag(py_reg, rd_q_reg.e1y);
    assign dex = diff_mag(px_reg, rd_q_reg.e2x);
    assign dey = diff_mag(py_reg, rd_q_reg.e2y);

    // micro-operation table: operands, sign and weight of each product
    always_comb
    begin
        ctrl.clear = 1'b0;
        ctrl.neg   = 1'b0;
        ctrl.shift = SH_NONE;
        mac_a      = '0;
        mac_b      = '0;
        case (op_reg)
            OP_H2: begin mac_a = A_W'(h_reg);   mac_b = B_W'(h_reg);   ctrl.clear = 1'b1; end
            OP_L0: begin mac_a = A_W'(mdx_reg); mac_b = B_W'(mdx_reg); ctrl.clear = 1'b1; end
            OP_L1: begin mac_a = A_W'(mdy_reg); mac_b = B_W'(mdy_reg); end
            OP_T0:
            begin
                mac_a = A_W'(mwx_reg); mac_b = B_W'(mdx_reg);
                ctrl.clear = 1'b1; ctrl.neg = swx_reg ^ sdx_reg;
            end
            OP_T1:
            begin
                mac_a = A_W'(mwy_reg); mac_b = B_W'(mdy_reg);
                ctrl.neg = swy_reg ^ sdy_reg;
            end
            OP_W0: begin mac_a = A_W'(mwx_reg); mac_b = B_W'(mwx_reg); ctrl.clear = 1'b1; end
            OP_W1: begin mac_a = A_W'(mwy_reg); mac_b = B_W'(mwy_reg); end
            OP_E0: begin mac_a = A_W'(mex_reg); mac_b = B_W'(mex_reg); ctrl.clear = 1'b1; end
            OP_E1: begin mac_a = A_W'(mey_reg); mac_b = B_W'(mey_reg); end
            OP_C0:
            begin
                mac_a = A_W'(mwx_reg); mac_b = B_W'(mdy_reg);
                ctrl.clear = 1'b1; ctrl.neg = swx_reg ^ sdy_reg;
            end
            OP_C1:
            begin
                mac_a = A_W'(mwy_reg); mac_b = B_W'(mdx_reg);
                ctrl.neg = !(swy_reg ^ sdx_reg);
            end
            OP_Q0:
            begin
                mac_a = A_W'(cr_reg[LO_W-1:0]); mac_b = cr_reg[LO_W-1:0];
                ctrl.clear = 1'b1;
            end
            OP_Q1:
            begin
                mac_a = A_W'(cr_reg[CR_W-1:LO_W]); mac_b = cr_reg[LO_W-1:0];
                ctrl.shift = SH_MID;
            end
            OP_Q2:
            begin
                mac_a = A_W'(cr_reg[CR_W-1:LO_W]); mac_b = B_W'(cr_reg[CR_W-1:LO_W]);
                ctrl.shift = SH_HI;
            end
            OP_R0:
            begin
                mac_a = h2_reg; mac_b = l_reg[LO_W-1:0];
                ctrl.clear = 1'b1;
            end
            OP_R1:
            begin
                mac_a = h2_reg; mac_b = B_W'(l_reg[L_W-1:LO_W]);
                ctrl.shift = SH_LO;
            end
            default: ;
        endcase
        ctrl.mul_en = (state_reg == S_MUL);
        ctrl.acc_en = (state_reg == S_ACC);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        idx_next   = idx_reg;
        done_next  = 1'b0;
        wq_next    = wq_reg;
        hit_next   = hit_reg;
        cross_next = cross_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == OPC_LOAD)
                    begin
                        done_next = 1'b1;
                        wq_next   = 1'b0;
                        hit_next  = 1'b0;
                    end
                    else if (n_walls == '0)
                    begin
                        done_next = 1'b1;
                        wq_next   = 1'b1;
                        hit_next  = 1'b0;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = S_RD;
                    end
                end
            end
            S_RD:   state_next = S_DIFF;
            S_DIFF:
            begin
                op_next    = OP_H2;
                state_next = S_MUL;
            end
            S_MUL:  state_next = S_ACC;
            S_ACC:
            begin
                state_next = S_MUL;
                case (op_reg)
                    OP_H2: op_next = OP_L0;
                    OP_L0: op_next = OP_L1;
                    OP_L1: op_next = OP_T0;
                    OP_T0: op_next = OP_T1;
                    OP_T1: state_next = S_SEL;
                    OP_W0: op_next = OP_W1;
                    OP_E0: op_next = OP_E1;
                    OP_C0: op_next = OP_C1;
                    OP_C1: state_next = S_CRM;
                    OP_Q0: op_next = OP_Q1;
                    OP_Q1: op_next = OP_Q2;
                    OP_Q2: op_next = OP_R0;
                    OP_R0: op_next = OP_R1;
                    default: state_next = S_CMP;
                endcase
            end
            S_SEL:
            begin
                state_next = S_MUL;
                if (l_reg == '0 || acc <= 0)
                begin
                    op_next    = OP_W0;
                    cross_next = 1'b0;
                end
                else if (acc >= signed'(ACC_W'(l_reg)))
                begin
                    op_next    = OP_E0;
                    cross_next = 1'b0;
                end
                else
                begin
                    op_next    = OP_C0;
                    cross_next = 1'b1;
                end
            end
            S_CRM:
            begin
                op_next    = OP_Q0;
                state_next = S_MUL;
            end
            S_CMP:
            begin
                if (wall_hit || last_wall)
                begin
                    done_next  = 1'b1;
                    wq_next    = 1'b1;
                    hit_next   = wall_hit;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + ADDR_W'(1);
                    state_next = S_RD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            op_reg     <= OP_H2;
            idx_reg    <= '0;
            done_reg   <= 1'b0;
            wq_reg     <= 1'b0;
            hit_reg    <= 1'b0;
            cross_reg  <= 1'b0;
            radius_reg <= RAD_W'(256);
            count_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
            wq_reg    <= wq_next;
            hit_reg   <= hit_next;
            cross_reg <= cross_next;
            if (cfg_wr)
            begin
                case (cfg_index)
                    REG_EGG_RADIUS: radius_reg <= cfg_data;
                    REG_WALL_COUNT: count_reg  <= cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // wall table and datapath holding registers
    always_ff @(posedge clk)
    begin
        if (accept && opcode == OPC_LOAD)
        begin
            wall_mem[wall_index] <= '{e1x: end1_x, e1y: end1_y, e2x: end2_x,
                                      e2y: end2_y, thick: wall_thickness};
        end
        rd_q_reg <= wall_mem[idx_reg];
        if (accept)
        begin
            px_reg <= point_x;
            py_reg <= point_y;
        end
        if (state_reg == S_DIFF)
        begin
            {sdx_reg, mdx_reg} <= dmx;
            {sdy_reg, mdy_reg} <= dmy;
            {swx_reg, mwx_reg} <= dwx;
            {swy_reg, mwy_reg} <= dwy;
            mex_reg <= dex[DW-1:0];
            mey_reg <= dey[DW-1:0];
            h_reg   <= {1'b0, radius_reg, 1'b0} + H_W'(rd_q_reg.thick);
        end
        // pick up finished sums as the next product starts
        if (state_reg == S_MUL)
        begin
            if (op_reg == OP_L0) h2_reg  <= acc_u[H2_W-1:0];
            if (op_reg == OP_T0) l_reg   <= acc_u[L_W-1:0];
            if (op_reg == OP_R0) lhs_reg <= acc_u << 2;
        end
        if (state_reg == S_CRM)
        begin
            cr_reg <= acc[ACC_W-1] ? CR_W'(-acc) : acc_u[CR_W-1:0];
        end
    end

`ifndef SYNTH
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while walking walls");

    a_load_ack: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && opcode == OPC_LOAD) |=> (done && !was_query && !hit))
        else $error("load not acknowledged on next cycle");

    a_busy_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && opcode == OPC_QUERY))
        else $error("walk started without a query");
`endif

endmodule

// File: dv/capsule_wall_hit_test_core_tb.sv
// ---------------------------------------------------------------------------
// capsule_wall_hit_test_core_tb - self-checking bench for the wall hit test
// Drives load and query words with random gaps, keeps its own wall table
// and exact integer hit predictor, and checks every done strobe in order.
// ---------------------------------------------------------------------------
module capsule_wall_hit_test_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cwht_pkg::*;

    localparam int WATCH_LIMIT = 20000;

    typedef struct {
        logic was_query;
        logic hit;
    } answer_t;

    typedef struct {
        bit                   setcfg;
        int                   rad;
        int                   cnt;
        logic                 op;
        int                   idx;
        logic signed [CW-1:0] e1x, e1y, e2x, e2y;
        int                   thk;
        logic signed [CW-1:0] px, py;
        bit                   typed;
        logic                 exp_hit;
    } row_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic                       cfg_wr = 1'b0;
    logic                       cfg_index = REG_EGG_RADIUS;
    logic [RAD_W-1:0]           cfg_data = '0;
    logic                       opcode = OPC_LOAD;
    logic [ADDR_W-1:0]          wall_index = '0;
    logic signed [CW-1:0]       end1_x = '0, end1_y = '0, end2_x = '0, end2_y = '0;
    logic [THK_W-1:0]           wall_thickness = '0;
    logic signed [CW-1:0]       point_x = '0, point_y = '0;
    logic                       done, was_query, hit;

    // predictor copy of the table and registers
    longint     tbl_e1x[MAX_WALLS], tbl_e1y[MAX_WALLS];
    longint     tbl_e2x[MAX_WALLS], tbl_e2y[MAX_WALLS];
    longint     tbl_thk[MAX_WALLS];
    int         radius_q = 256;
    int         count_q = 0;
    answer_t    pending_answers[$];
    int         errors = 0;
    int         idle_cycles = 0;

    capsule_wall_hit_test_core uut (.*);

    always #5 clk = ~clk;

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    function automatic bit wall_touched(input int i, input longint px, input longint py);
        longint      h2, wx, wy, dx, dy, l, t, ex, ey, cr;
        logic [127:0] lhs, rhs;
        h2 = (2 * radius_q + tbl_thk[i]) * (2 * radius_q + tbl_thk[i]);
        wx = px - tbl_e1x[i];
        wy = py - tbl_e1y[i];
        dx = tbl_e2x[i] - tbl_e1x[i];
        dy = tbl_e2y[i] - tbl_e1y[i];
        l  = dx * dx + dy * dy;
        t  = wx * dx + wy * dy;
        if (l == 0 || t <= 0)
            return 4 * (wx * wx + wy * wy) <= h2;
        if (t >= l)
        begin
            ex = px - tbl_e2x[i];
            ey = py - tbl_e2y[i];
            return 4 * (ex * ex + ey * ey) <= h2;
        end
        cr  = wx * dy - wy * dx;
        if (cr < 0)
            cr = -cr;
        lhs = 128'(cr) * 128'(cr) * 128'd4;
        rhs = 128'(h2) * 128'(l);
        return lhs <= rhs;
    endfunction

    function automatic logic point_hits(input longint px, input longint py);
        int n;
        n = count_q > MAX_WALLS ? MAX_WALLS : count_q;
        for (int i = 0; i < n; i++)
            if (wall_touched(i, px, py))
                return 1'b1;
        return 1'b0;
    endfunction

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input int value);
        cfg_wr    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= RAD_W'(value);
        @(posedge clk);
        cfg_wr    <= 1'b0;
        if (idx == REG_EGG_RADIUS)
            radius_q = value & 10'h3FF;
        else
            count_q = value & 7'h7F;
    endtask

    task automatic set_regs(input int rad, input int cnt);
        wait_idle();
        write_reg(REG_EGG_RADIUS, rad);
        write_reg(REG_WALL_COUNT, cnt);
    endtask

    // offer one word, hold it until taken, then log its expected answer
    task automatic send_word(input row_t r);
        int      gap;
        answer_t a;
        gap = $urandom_range(0, 5);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start          <= 1'b1;
        opcode         <= r.op;
        wall_index     <= ADDR_W'(r.idx);
        end1_x         <= r.e1x;
        end1_y         <= r.e1y;
        end2_x         <= r.e2x;
        end2_y         <= r.e2y;
        wall_thickness <= THK_W'(r.thk);
        point_x        <= r.px;
        point_y        <= r.py;
        do
            @(posedge clk);
        while (busy);
        a.was_query = r.op;
        if (r.op == OPC_LOAD)
        begin
            tbl_e1x[r.idx] = r.e1x;
            tbl_e1y[r.idx] = r.e1y;
            tbl_e2x[r.idx] = r.e2x;
            tbl_e2y[r.idx] = r.e2y;
            tbl_thk[r.idx] = r.thk;
            a.hit = 1'b0;
        end
        else
            a.hit = point_hits(r.px, r.py);
        if (r.typed)
            a.hit = r.exp_hit;
        pending_answers.push_back(a);
    endtask

    function automatic logic signed [CW-1:0] coord(input longint centre, input int span);
        if ($urandom_range(0, 9) == 0)
            return CW'($urandom);
        return CW'(centre + longint'($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic row_t random_word(input bit force_load, input int idx);
        row_t r;
        int   k, span;
        r      = '{default: 0};
        span   = ($urandom_range(0, 3) == 0) ? 40000 : 3000;
        r.op   = (force_load || $urandom_range(0, 3) == 0) ? OPC_LOAD : OPC_QUERY;
        r.idx  = force_load ? idx : $urandom_range(0, MAX_WALLS - 1);
        r.e1x  = coord(0, span);
        r.e1y  = coord(0, span);
        r.e2x  = ($urandom_range(0, 9) == 0) ? r.e1x : coord(r.e1x, span);
        r.e2y  = ($urandom_range(0, 9) == 0) ? r.e1y : coord(r.e1y, span);
        r.thk  = $urandom_range(0, 1023);
        // aim most queries near a stored wall so hits and misses both occur
        k      = $urandom_range(0, MAX_WALLS - 1);
        r.px   = coord((tbl_e1x[k] + tbl_e2x[k]) / 2, 2500);
        r.py   = coord((tbl_e1y[k] + tbl_e2y[k]) / 2, 2500);
        return r;
    endfunction

    // result side: done is accepted at the edge that ends its cycle
    always @(posedge clk)
    begin
        answer_t a;
        if (rst_n && done)
        begin
            if (pending_answers.size() == 0)
                report("result with nothing expected");
            else
            begin
                a = pending_answers.pop_front();
                if (was_query !== a.was_query)
                    report($sformatf("was_query %b, expected %b", was_query, a.was_query));
                if (hit !== a.hit)
                    report($sformatf("hit %b, expected %b", hit, a.hit));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    localparam logic signed [CW-1:0] CMAX = 19'sh3FFFF;
    localparam logic signed [CW-1:0] CMIN = -19'sh40000;

    initial
    begin
        row_t directed[$];
        row_t r;
        int   rad, cnt;

        r = '{default: 0};
        // zero count: no wall checked
        r.op = OPC_QUERY; r.px = CMAX; r.py = CMAX; r.typed = 1; directed.push_back(r);
        r.px = CMIN; r.py = CMIN; directed.push_back(r);
        // loads at the extremes are acknowledged with hit low
        r = '{default: 0}; r.op = OPC_LOAD; r.typed = 1;
        r.idx = 0; r.e1x = CMAX; r.e1y = CMAX; r.e2x = CMIN; r.e2y = CMIN; r.thk = 1023;
        r.px = CMAX; r.py = CMIN; directed.push_back(r);
        r.idx = 1; r.e1x = 0; r.e1y = 0; r.e2x = 0; r.e2y = 0; r.thk = 0;
        directed.push_back(r);
        r.idx = 2; r.e2x = 1600; directed.push_back(r);
        r.idx = 63; r.e1x = CMIN; r.e1y = CMAX; r.e2x = CMAX; r.e2y = CMIN; r.thk = 512;
        directed.push_back(r);
        r = '{default: 0}; r.op = OPC_QUERY;
        r.setcfg = 1; r.rad = 0; r.cnt = 3;
        r.px = CMAX; r.py = CMAX; r.typed = 1; r.exp_hit = 1; directed.push_back(r);
        r = '{default: 0}; r.op = OPC_QUERY;
        r.px = 0;    r.py = 0;  directed.push_back(r);
        r.px = 800;  r.py = 10; directed.push_back(r);
        r.px = 800;  r.py = 600; directed.push_back(r);
        r.px = -100; r.py = 0;  directed.push_back(r);
        r.px = 1700; r.py = 0;  directed.push_back(r);
        r.setcfg = 1; r.rad = 1023; r.cnt = 2; r.px = 5000; r.py = 0; directed.push_back(r);
        r.setcfg = 0; r.px = CMIN; r.py = CMIN; r.typed = 1; r.exp_hit = 1;
        directed.push_back(r);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].setcfg)
                set_regs(directed[i].rad, directed[i].cnt);
            send_word(directed[i]);
        end

        // fill the whole table so any count is legal from here on
        for (int i = 0; i < MAX_WALLS; i++)
            send_word(random_word(1, i));

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: begin rad = 256;  cnt = 64;  end
                1: begin rad = 0;    cnt = 1;   end
                2: begin rad = 1023; cnt = 127; end
                3: begin rad = 0;    cnt = 0;   end
                4: begin rad = 1023; cnt = 100; end
                default:
                begin
                    rad = $urandom_range(0, 1023);
                    cnt = $urandom_range(0, 64);
                end
            endcase
            set_regs(rad, cnt);
            for (int n = 0; n < 100; n++)
                send_word(random_word(0, 0));
        end

        wait_idle();
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
